// File: sv/hbp_pkg.sv
// Shared types and constants for the Huffman bit packer.
`default_nettype none

package hbp_pkg;

	localparam int BYTE_W = 8;
	localparam int SYM_W  = 8;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int OP_W   = 2;
	localparam int KIND_W = 2;
	localparam int BUF_W  = 7;
	localparam int CNT_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA  = 2'd0,
		KIND_PAD   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT,
		ST_FLUSH_DATA,
		ST_FLUSH_PAD
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} code_entry_t;

endpackage

`default_nettype wire

// File: sv/hbp_cmd_if.sv
// Input channel of the Huffman bit packer: load, encode and flush items.
`default_nettype none

interface hbp_cmd_if import hbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [SYM_W-1:0]  symbol;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0]  code_len;

	modport source (output valid, output op, output symbol, output code_bits,
		output code_len, input ready);
	modport sink (input valid, input op, input symbol, input code_bits,
		input code_len, output ready);
endinterface

`default_nettype wire

// File: sv/hbp_res_if.sv
// Output channel of the Huffman bit packer: packed bytes, trailers and errors.
`default_nettype none

interface hbp_res_if import hbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [KIND_W-1:0] kind;
	logic              last;

	modport source (output valid, output out_byte, output kind, output last,
		input ready);
	modport sink (input valid, input out_byte, input kind, input last,
		output ready);
endinterface

`default_nettype wire

// File: sv/hbp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module hbp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/huffman_bit_packer.sv
// Top level of the Huffman bit packer: code table, bit buffer and byte output.
`default_nettype none

// Packs prefix codes MSB first into bytes. A load item writes one entry of the
// code table. An encode item passes the table RAM read and the merge with the
// pending bits, then produces one result per full byte, up to (MAX_CODE_LEN + 7) / 8
// bytes; an unknown symbol gives one error result. A flush gives the partial
// byte, if any, and the padding-count trailer. Results go out through a single
// output register, one per cycle while the sink is ready, and the input is taken
// again as soon as the last result of an item is in that register.
module huffman_bit_packer import hbp_pkg::*; #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOLS      = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	hbp_cmd_if.sink cmd,
	hbp_res_if.source res
);

	localparam int AW    = $clog2(SYMBOLS);
	localparam int ACC_W = MAX_CODE_LEN + BUF_W;
	localparam int TOT_W = $clog2(ACC_W + 1);

	state_t state_q, state_d;

	logic               accept;
	logic               in_range;
	logic [AW-1:0]      idx;
	logic               too_long;
	logic [CODE_W-1:0]  len_mask;
	code_entry_t        wr_entry;
	code_entry_t        rd_entry;
	logic               load_en;
	logic               read_en;

	logic [SYMBOLS-1:0] present_q;
	logic               present_s1;

	logic [BUF_W-1:0]   buf_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [ACC_W-1:0]   acc_w;
	logic [TOT_W-1:0]   total_w;
	logic [BUF_W-1:0]   keep_mask;
	logic [ACC_W-1:0]   acc_q;
	logic [TOT_W-1:0]   total_q;
	logic               err_q;
	logic [TOT_W-1:0]   rem;
	logic [ACC_W-1:0]   window;

	logic [CNT_W-1:0]   pad;
	logic [BYTE_W-1:0]  partial;

	logic               out_free;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	kind_t              out_kind_q;
	logic               out_last_q;

	logic               push;
	logic [BYTE_W-1:0]  push_byte;
	kind_t              push_kind;
	logic               push_last;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	assign in_range = {1'b0, cmd.symbol} < (SYM_W + 1)'(SYMBOLS);
	assign idx      = cmd.symbol[AW-1:0];

	// Entries longer than the supported maximum are stored as absent.
	assign too_long = cmd.code_len > LEN_W'(MAX_CODE_LEN);
	assign len_mask = (cmd.code_len >= LEN_W'(CODE_W)) ? '1 : ~('1 << cmd.code_len);
	assign wr_entry.len  = too_long ? '0 : cmd.code_len;
	assign wr_entry.bits = too_long ? '0 : (cmd.code_bits & len_mask);

	assign load_en = accept && (cmd.op == OP_LOAD) && in_range;
	assign read_en = accept && (cmd.op == OP_ENCODE);

	hbp_ram #(
		.WIDTH ($bits(code_entry_t)),
		.DEPTH (SYMBOLS)
	) u_table (
		.clk     (clk),
		.wr_en   (load_en),
		.wr_addr (idx),
		.wr_data (wr_entry),
		.rd_en   (read_en),
		.rd_addr (idx),
		.rd_data (rd_entry)
	);

	// Merge the pending bits with the code read from the table.
	assign acc_w     = (ACC_W'(buf_q) << rd_entry.len) | ACC_W'(rd_entry.bits);
	assign total_w   = TOT_W'(cnt_q) + TOT_W'(rd_entry.len);
	assign keep_mask = BUF_W'((8'd1 << total_w[CNT_W-1:0]) - 8'd1);

	assign rem    = total_q - TOT_W'(BYTE_W);
	assign window = acc_q >> rem;

	assign pad     = CNT_W'(0) - cnt_q;
	assign partial = BYTE_W'({1'b0, buf_q}) << pad;

	assign out_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		push_byte = '0;
		push_kind = KIND_DATA;
		push_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.op)
						OP_ENCODE: state_d = ST_LOOKUP;
						OP_FLUSH:  state_d = (cnt_q != '0) ? ST_FLUSH_DATA : ST_FLUSH_PAD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: begin
				if (!present_s1 || total_w >= TOT_W'(BYTE_W)) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					push = 1'b1;
					if (err_q) begin
						push_kind = KIND_ERROR;
						push_last = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						push_byte = window[BYTE_W-1:0];
						push_last = rem < TOT_W'(BYTE_W);
						if (push_last) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_FLUSH_DATA: begin
				if (out_free) begin
					push      = 1'b1;
					push_byte = partial;
					state_d   = ST_FLUSH_PAD;
				end
			end
			ST_FLUSH_PAD: begin
				if (out_free) begin
					push      = 1'b1;
					push_byte = BYTE_W'(pad);
					push_kind = KIND_PAD;
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Table presence bits and the pending bit buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			buf_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (load_en) begin
				present_q[idx] <= !too_long && (cmd.code_len != '0);
			end
			if (state_q == ST_LOOKUP && present_s1) begin
				buf_q <= acc_w[BUF_W-1:0] & keep_mask;
				cnt_q <= total_w[CNT_W-1:0];
			end else if (state_q == ST_FLUSH_PAD && out_free) begin
				buf_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (read_en) begin
			present_s1 <= in_range && present_q[idx];
		end
		if (state_q == ST_LOOKUP) begin
			acc_q   <= acc_w;
			total_q <= total_w;
			err_q   <= !present_s1;
		end else if (state_q == ST_EMIT && push && !err_q) begin
			total_q <= rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_byte_q <= push_byte;
			out_kind_q <= push_kind;
			out_last_q <= push_last;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.out_byte = out_byte_q;
	assign res.kind     = out_kind_q;
	assign res.last     = out_last_q;

`ifndef ASSERT_OFF
	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> err_q || total_q >= TOT_W'(BYTE_W))
		else $error("emit state entered without a full byte or an error");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == KIND_ERROR |-> res.last && res.out_byte == '0)
		else $error("error result must be a last zero byte");

	a_trailer_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == KIND_PAD |-> res.last && res.out_byte < BYTE_W'(BYTE_W))
		else $error("trailer must be last and hold a count below eight");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH_PAD && out_free |=> cnt_q == '0 && buf_q == '0)
		else $error("bit buffer not cleared after the trailer");
`endif

endmodule

`default_nettype wire
